// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the request head parser.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define HRHP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Implication into the next cycle.
`define HRHP_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    `HRHP_ASSERT(lbl, clk, rstn, (pre) |=> (post), msg)

`endif

// ===== hw/rtl/hrhp_pkg.sv =====
// Package of the HTTP request head parser: word types and result codes.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps

package hrhp_pkg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [2:0]  byte_role;
        logic        starts_header;
        logic [15:0] version_major;
        logic [15:0] version_minor;
    } out_word_t;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    localparam logic [1:0] VERDICT_MORE = 2'd0;
    localparam logic [1:0] VERDICT_DONE = 2'd1;
    localparam logic [1:0] VERDICT_BAD  = 2'd2;

    localparam logic [2:0] ROLE_NONE   = 3'd0;
    localparam logic [2:0] ROLE_METHOD = 3'd1;
    localparam logic [2:0] ROLE_URI    = 3'd2;
    localparam logic [2:0] ROLE_NAME   = 3'd3;
    localparam logic [2:0] ROLE_VALUE  = 3'd4;

    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_US    = 8'h1F;

    localparam logic [15:0] VERSION_MAX = 16'hFFFF;

endpackage

// ===== hw/rtl/http_request_head_parser_top.sv =====
// Top level of the HTTP request head parser: byte-wise request line and header walk.
// Depends on hrhp_pkg for the word types, result codes and character constants.
//
//   channel | direction | ports                      | word
//   s_      | in        | s_valid s_ready s_data     | hrhp_pkg::in_word_t
//   m_      | out       | m_valid m_ready m_data     | hrhp_pkg::out_word_t
//
// One word is taken per cycle while the result is not stalled. A word is held in
// the input register, is judged combinationally against the parse state and lands
// in the result register, from which its result is shown. While a result waits, the
// input register takes a word only when it is empty. Reset is synchronous and
// returns the parser to the start of a request; a stalled result holds its word.
`timescale 1ns / 1ps

module http_request_head_parser_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrhp_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hrhp_pkg::out_word_t m_data
);

    typedef enum logic [4:0] {
        ST_METHOD_START = 5'd0,
        ST_METHOD       = 5'd1,
        ST_URI          = 5'd2,
        ST_VER_H        = 5'd3,
        ST_VER_T1       = 5'd4,
        ST_VER_T2       = 5'd5,
        ST_VER_P        = 5'd6,
        ST_VER_SLASH    = 5'd7,
        ST_MAJOR_START  = 5'd8,
        ST_MAJOR        = 5'd9,
        ST_MINOR_START  = 5'd10,
        ST_MINOR        = 5'd11,
        ST_LF1          = 5'd12,
        ST_LINE_START   = 5'd13,
        ST_LWS          = 5'd14,
        ST_NAME         = 5'd15,
        ST_SPACE        = 5'd16,
        ST_VALUE        = 5'd17,
        ST_LF2          = 5'd18,
        ST_LF3          = 5'd19
    } state_t;

    function automatic logic is_control(input logic [7:0] b);
        return (b <= hrhp_pkg::CH_US) || (b == hrhp_pkg::CH_DEL);
    endfunction

    function automatic logic is_separator(input logic [7:0] b);
        logic sep;
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[",
            "]", "?", "=", "{", "}", hrhp_pkg::CH_SP, hrhp_pkg::CH_HT: begin
                sep = 1'b1;
            end
            default: begin
                sep = 1'b0;
            end
        endcase
        return sep;
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        return !b[7] && !is_control(b) && !is_separator(b);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    // acc * 10 + digit as two shifted adds, saturating at the top of 16 bits.
    function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] b);
        logic [19:0] sum;
        sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, b[3:0]};
        return (sum > {4'b0, hrhp_pkg::VERSION_MAX}) ? hrhp_pkg::VERSION_MAX : sum[15:0];
    endfunction

    logic                in_valid_reg;
    hrhp_pkg::in_word_t  in_data_reg;
    logic                m_valid_reg;
    hrhp_pkg::out_word_t m_data_reg;

    state_t      state_reg, state_next;
    logic        header_seen_reg, header_seen_next;
    logic [15:0] major_reg, major_next;
    logic [15:0] minor_reg, minor_next;

    logic [1:0]  verdict;
    logic [2:0]  role;
    logic        starts;
    logic [7:0]  cur_byte;
    logic        advance;

    assign advance  = !m_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign cur_byte = in_data_reg.data_byte;

    always_comb begin
        state_next       = state_reg;
        header_seen_next = header_seen_reg;
        major_next       = major_reg;
        minor_next       = minor_reg;
        verdict          = hrhp_pkg::VERDICT_MORE;
        role             = hrhp_pkg::ROLE_NONE;
        starts           = 1'b0;
        if (in_data_reg.req_type == hrhp_pkg::REQ_RESTART) begin
            state_next       = ST_METHOD_START;
            header_seen_next = 1'b0;
            major_next       = '0;
            minor_next       = '0;
        end else begin
            case (state_reg)
                ST_METHOD_START: begin
                    if (is_token(cur_byte)) begin
                        state_next = ST_METHOD;
                        role       = hrhp_pkg::ROLE_METHOD;
                    end else begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end
                end
                ST_METHOD: begin
                    if (cur_byte == hrhp_pkg::CH_SP) begin
                        state_next = ST_URI;
                    end else if (is_token(cur_byte)) begin
                        role = hrhp_pkg::ROLE_METHOD;
                    end else begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end
                end
                ST_URI: begin
                    if (cur_byte == hrhp_pkg::CH_SP) begin
                        state_next = ST_VER_H;
                    end else if (is_control(cur_byte)) begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end else begin
                        role = hrhp_pkg::ROLE_URI;
                    end
                end
                ST_VER_H: begin
                    if (cur_byte == hrhp_pkg::CH_H) state_next = ST_VER_T1;
                    else verdict = hrhp_pkg::VERDICT_BAD;
                end
                ST_VER_T1: begin
                    if (cur_byte == hrhp_pkg::CH_T) state_next = ST_VER_T2;
                    else verdict = hrhp_pkg::VERDICT_BAD;
                end
                ST_VER_T2: begin
                    if (cur_byte == hrhp_pkg::CH_T) state_next = ST_VER_P;
                    else verdict = hrhp_pkg::VERDICT_BAD;
                end
                ST_VER_P: begin
                    if (cur_byte == hrhp_pkg::CH_P) state_next = ST_VER_SLASH;
                    else verdict = hrhp_pkg::VERDICT_BAD;
                end
                ST_VER_SLASH: begin
                    if (cur_byte == hrhp_pkg::CH_SLASH) begin
                        major_next = '0;
                        minor_next = '0;
                        state_next = ST_MAJOR_START;
                    end else begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end
                end
                ST_MAJOR_START: begin
                    if (is_digit(cur_byte)) begin
                        major_next = add_digit(major_reg, cur_byte);
                        state_next = ST_MAJOR;
                    end else begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end
                end
                ST_MAJOR: begin
                    if (cur_byte == hrhp_pkg::CH_DOT) begin
                        state_next = ST_MINOR_START;
                    end else if (is_digit(cur_byte)) begin
                        major_next = add_digit(major_reg, cur_byte);
                    end else begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end
                end
                ST_MINOR_START: begin
                    if (is_digit(cur_byte)) begin
                        minor_next = add_digit(minor_reg, cur_byte);
                        state_next = ST_MINOR;
                    end else begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end
                end
                ST_MINOR: begin
                    if (cur_byte == hrhp_pkg::CH_CR) begin
                        state_next = ST_LF1;
                    end else if (is_digit(cur_byte)) begin
                        minor_next = add_digit(minor_reg, cur_byte);
                    end else begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end
                end
                ST_LF1: begin
                    if (cur_byte == hrhp_pkg::CH_LF) state_next = ST_LINE_START;
                    else verdict = hrhp_pkg::VERDICT_BAD;
                end
                ST_LINE_START: begin
                    if (cur_byte == hrhp_pkg::CH_CR) begin
                        state_next = ST_LF3;
                    end else if (header_seen_reg && (cur_byte == hrhp_pkg::CH_SP ||
                                                     cur_byte == hrhp_pkg::CH_HT)) begin
                        state_next = ST_LWS;
                    end else if (is_token(cur_byte)) begin
                        header_seen_next = 1'b1;
                        state_next       = ST_NAME;
                        role             = hrhp_pkg::ROLE_NAME;
                        starts           = 1'b1;
                    end else begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end
                end
                ST_LWS: begin
                    if (cur_byte == hrhp_pkg::CH_CR) begin
                        state_next = ST_LF2;
                    end else if (cur_byte == hrhp_pkg::CH_SP || cur_byte == hrhp_pkg::CH_HT) begin
                        state_next = ST_LWS;
                    end else if (is_control(cur_byte)) begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end else begin
                        state_next = ST_VALUE;
                        role       = hrhp_pkg::ROLE_VALUE;
                    end
                end
                ST_NAME: begin
                    if (cur_byte == hrhp_pkg::CH_COLON) begin
                        state_next = ST_SPACE;
                    end else if (is_token(cur_byte)) begin
                        role = hrhp_pkg::ROLE_NAME;
                    end else begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end
                end
                ST_SPACE: begin
                    if (cur_byte == hrhp_pkg::CH_SP) state_next = ST_VALUE;
                    else verdict = hrhp_pkg::VERDICT_BAD;
                end
                ST_VALUE: begin
                    if (cur_byte == hrhp_pkg::CH_CR) begin
                        state_next = ST_LF2;
                    end else if (is_control(cur_byte)) begin
                        verdict = hrhp_pkg::VERDICT_BAD;
                    end else begin
                        role = hrhp_pkg::ROLE_VALUE;
                    end
                end
                ST_LF2: begin
                    if (cur_byte == hrhp_pkg::CH_LF) state_next = ST_LINE_START;
                    else verdict = hrhp_pkg::VERDICT_BAD;
                end
                ST_LF3: begin
                    if (cur_byte == hrhp_pkg::CH_LF) verdict = hrhp_pkg::VERDICT_DONE;
                    else verdict = hrhp_pkg::VERDICT_BAD;
                end
                default: begin
                    verdict = hrhp_pkg::VERDICT_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            state_reg       <= ST_METHOD_START;
            header_seen_reg <= 1'b0;
            major_reg       <= '0;
            minor_reg       <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && advance) begin
                state_reg       <= state_next;
                header_seen_reg <= header_seen_next;
                major_reg       <= major_next;
                minor_reg       <= minor_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (in_valid_reg && advance) begin
            m_data_reg.verdict       <= verdict;
            m_data_reg.byte_role     <= role;
            m_data_reg.starts_header <= starts;
            m_data_reg.version_major <= major_next;
            m_data_reg.version_minor <= minor_next;
        end
    end

endmodule

// ===== hw/rtl/hrhp_checker.sv =====
// Port checker of the HTTP request head parser, bound to the top level.
// Depends on hrhp_pkg and on the macros in assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hrhp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input hrhp_pkg::in_word_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input hrhp_pkg::out_word_t m_data
);

    logic bad_word;
    logic done_word;
    logic start_word;
    logic in_seen;

    assign bad_word   = m_valid && (m_data.verdict == hrhp_pkg::VERDICT_BAD);
    assign done_word  = m_valid && (m_data.verdict == hrhp_pkg::VERDICT_DONE);
    assign start_word = m_valid && m_data.starts_header;
    assign in_seen    = s_valid && s_ready && (s_data.req_type == hrhp_pkg::REQ_RESTART);

    `HRHP_ASSERT(a_bad_no_role, aclk, aresetn, bad_word |-> (m_data.byte_role == hrhp_pkg::ROLE_NONE && !m_data.starts_header), "malformed word carries a role")
    `HRHP_ASSERT(a_done_no_role, aclk, aresetn, done_word |-> (m_data.byte_role == hrhp_pkg::ROLE_NONE && !m_data.starts_header), "complete word carries a role")
    `HRHP_ASSERT(a_start_is_name, aclk, aresetn, start_word |-> (m_data.byte_role == hrhp_pkg::ROLE_NAME && m_data.verdict == hrhp_pkg::VERDICT_MORE), "header start on a word that is not a name byte")
    `HRHP_ASSERT_NEXT(a_restart_taken, aclk, aresetn, in_seen, (s_ready || m_valid), "restart word left no trace at the ports")
    `HRHP_ASSERT_NEXT(a_out_hold, aclk, aresetn, (m_valid && !m_ready), (m_valid && $stable(m_data)), "stalled result changed")

endmodule

bind http_request_head_parser_top hrhp_checker u_hrhp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
